FILE: design/smcd_pkg.sv
// ----------------------------------------------------------------------------
// Switch matrix change debouncer package
// Shared constants, lane control type and the chain byte-reversal function.
// ----------------------------------------------------------------------------
package smcd_pkg;

  // Number of switches on the chain (8..64)
  localparam int SWITCHES    = 64;
  localparam int FRAME_W     = 64;
  localparam int CHAIN_BYTES = (SWITCHES + 7) / 8;
  localparam int TIMER_W     = 4;

  localparam logic [TIMER_W-1:0] SETTLE_RESET = TIMER_W'(9);
  localparam logic [TIMER_W-1:0] TIMER_IDLE   = TIMER_W'(0);
  localparam logic [TIMER_W-1:0] TIMER_EXPIRE = TIMER_W'(1);

  // Bits that carry a real switch
  localparam logic [FRAME_W-1:0] SW_MASK =
    (SWITCHES >= FRAME_W) ? {FRAME_W{1'b1}}
                          : ((FRAME_W'(1) << SWITCHES) - FRAME_W'(1));

  // Per-lane control: step and settle are shared by all lanes, change is per switch
  typedef struct packed {
    logic               step;    // primed frame accepted this cycle
    logic               change;  // this switch differs from last frame
    logic [TIMER_W-1:0] settle;  // countdown start value
  } smcd_lane_ctrl_t;

  // Reverse byte order over the chain length and drop unused switch bits
  function automatic logic [FRAME_W-1:0] reverse_chain(input logic [FRAME_W-1:0] raw);
    logic [FRAME_W-1:0] r;
    r = '0;
    for (int k = 0; k < CHAIN_BYTES; k++) begin
      r[8*(CHAIN_BYTES-1-k) +: 8] = raw[8*k +: 8];
    end
    return r & SW_MASK;
  endfunction

endpackage

FILE: design/smcd_lane.sv
// ----------------------------------------------------------------------------
// Debounce lane
// One switch's settle countdown; flags the frame in which it expires.
// ----------------------------------------------------------------------------
module smcd_lane
  import smcd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  smcd_lane_ctrl_t ctrl,
  output logic            fire
);

  logic [TIMER_W-1:0] timer_r;
  logic [TIMER_W-1:0] timer_nxt;

  // Expiry wins over cancellation; both leave the timer idle
  always_comb begin
    timer_nxt = timer_r;
    if (ctrl.step) begin
      if (timer_r == TIMER_EXPIRE) begin
        timer_nxt = TIMER_IDLE;
      end else if (ctrl.change) begin
        timer_nxt = (timer_r != TIMER_IDLE) ? TIMER_IDLE : ctrl.settle;
      end else if (timer_r > TIMER_EXPIRE) begin
        timer_nxt = timer_r - TIMER_W'(1);
      end
    end
  end

  assign fire = ctrl.step && (timer_r == TIMER_EXPIRE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= TIMER_IDLE;
    end else begin
      timer_r <= timer_nxt;
    end
  end

endmodule

FILE: design/smcd_merge.sv
// ----------------------------------------------------------------------------
// Result merge stage
// Gathers the lane fire bits and the change mask into the output register.
// ----------------------------------------------------------------------------
module smcd_merge
  import smcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [FRAME_W-1:0] fire_vec,
  input  logic [FRAME_W-1:0] change_vec,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FRAME_W-1:0] out_fire_mask,
  output logic [FRAME_W-1:0] out_change_mask,
  output logic               busy
);

  logic               valid_r;
  logic               valid_nxt;
  logic [FRAME_W-1:0] fire_r;
  logic [FRAME_W-1:0] change_r;

  // Register holds a result that the receiver has not yet taken
  assign busy = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      fire_r   <= fire_vec & SW_MASK;
      change_r <= change_vec & SW_MASK;
    end
  end

  assign out_valid       = valid_r;
  assign out_fire_mask   = fire_r;
  assign out_change_mask = change_r;

endmodule

FILE: design/switch_matrix_change_debouncer.sv
// ----------------------------------------------------------------------------
// Switch matrix change debouncer
// Per-switch settle countdown over byte-reversed scan frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one raw scan frame per request.
//   The frame is byte-reversed over the chain and compared with the last one.
//   Output channel out_valid/out_stall returns one request per frame:
//   out_fire_mask (countdowns expired) and out_change_mask (switches moved).
//   The result is registered: it is shown in the cycle after its frame is accepted.
//   Throughput is one frame per cycle while out_stall is low; every switch
//   has its own timer lane, so only the single output register sets the rate.
//   When the receiver stalls the output register holds its request and
//   in_stall rises, so at most one result is buffered.
//   cfg_wr_en/cfg_wr_data set the settle count; write it while idle.
//   Reset (rst_n low, synchronous) clears all timers, the stored sample and
//   the primed flag, and sets the settle count to 9. The first frame after
//   reset only primes the stored sample and returns both masks as zero.
// ----------------------------------------------------------------------------
module switch_matrix_change_debouncer
  import smcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FRAME_W-1:0] in_raw_frame,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FRAME_W-1:0] out_fire_mask,
  output logic [FRAME_W-1:0] out_change_mask,
  input  logic               cfg_wr_en,
  input  logic [TIMER_W-1:0] cfg_wr_data
);

  logic [TIMER_W-1:0] settle_r;
  logic [FRAME_W-1:0] prev_sample_r;
  logic               primed_r;
  logic [FRAME_W-1:0] sample;
  logic [FRAME_W-1:0] change_vec;
  logic [FRAME_W-1:0] fire_vec;
  logic               in_accept;
  logic               busy;

  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  // Frame alignment and change detection
  assign sample     = reverse_chain(in_raw_frame);
  assign change_vec = primed_r ? ((sample ^ prev_sample_r) & SW_MASK) : '0;

  // Configuration and frame history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r      <= SETTLE_RESET;
      prev_sample_r <= '0;
      primed_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        settle_r <= cfg_wr_data;
      end
      if (in_accept) begin
        prev_sample_r <= sample;
        primed_r      <= 1'b1;
      end
    end
  end

  // One timer lane per switch
  for (genvar i = 0; i < FRAME_W; i++) begin : g_lane
    if (i < SWITCHES) begin : g_on
      smcd_lane_ctrl_t ctrl;
      assign ctrl.step   = in_accept && primed_r;
      assign ctrl.change = change_vec[i];
      assign ctrl.settle = settle_r;
      smcd_lane u_lane (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (ctrl),
        .fire (fire_vec[i])
      );
    end else begin : g_off
      assign fire_vec[i] = 1'b0;
    end
  end

  // Output register
  smcd_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (in_accept),
    .fire_vec       (fire_vec),
    .change_vec     (change_vec),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fire_mask  (out_fire_mask),
    .out_change_mask(out_change_mask),
    .busy           (busy)
  );

  // Priming frame gives an empty result
  a_prime_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_accept && !primed_r |=>
      out_valid && (out_fire_mask == '0) && (out_change_mask == '0))
    else $error("priming frame produced a non-empty result");

  // Every accepted frame leaves a result in the output register
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_accept |=> out_valid)
    else $error("accepted frame lost");

  // No result bits beyond the switch count
  a_unused_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((out_fire_mask | out_change_mask) & ~SW_MASK) == '0))
    else $error("result bit set above switch count");

  // A lane fires only on an accepted frame after priming, never on the priming frame
  a_fire_primed: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_vec != '0) |-> (primed_r && in_accept))
    else $error("lane fired outside a primed frame");

endmodule
